[rtl/srcbi_pkg.sv]
package srcbi_pkg;

  // Field widths of the rank, count and slot words.
  localparam int unsigned DATA_W     = 16;
  // Number of descent levels, one cell each.
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned HW         = $clog2(DATA_W + 1);

  // Configuration register map (byte addresses).
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_ELEMENT_COUNT = ADDR_W'(0);
  localparam logic [DATA_W-1:0] ELEMENT_COUNT_RESET = DATA_W'(1);

  // Descent state carried from one cell to the next.
  typedef struct packed {
    logic [DATA_W-1:0] rank;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] slot;
    logic              active;  // still descending
    logic              found;   // rank hit a subtree root
  } cell_state_t;

  // Bit length of a nonzero-or-zero word.
  function automatic logic [HW-1:0] bit_length(input logic [DATA_W-1:0] n);
    logic [HW-1:0] h;
    h = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (n[i]) h = HW'(i + 1);
    end
    return h;
  endfunction

  // Rank of the root of a complete search tree holding n elements.
  function automatic logic [DATA_W-1:0] subtree_root(input logic [DATA_W-1:0] n);
    logic [HW-1:0]     h;
    logic [DATA_W-1:0] full;
    logic [DATA_W-1:0] fill;
    logic [DATA_W-1:0] half;
    logic [DATA_W-1:0] root;
    h    = bit_length(n);
    full = '0;
    half = '0;
    if (h >= HW'(2)) begin
      full = (DATA_W'(1) << (h - HW'(1))) - DATA_W'(1);
      half = DATA_W'(1) << (h - HW'(2));
    end
    fill = n - full;
    if (n <= DATA_W'(1)) begin
      root = '0;
    end else if (half > fill) begin
      root = full - (half - fill);
    end else begin
      root = full;
    end
    return root;
  endfunction

endpackage

[rtl/srcbi_cell.sv]
module srcbi_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  srcbi_pkg::cell_state_t up_state,
  output logic                up_ready,
  output logic                dn_valid,
  output srcbi_pkg::cell_state_t dn_state,
  input  logic                dn_ready
);
  import srcbi_pkg::*;

  logic              valid;
  cell_state_t       state;
  cell_state_t       state_next;
  logic [DATA_W-1:0] root;
  logic [DATA_W-1:0] step;

  // One level of descent: compare against the subtree root and go left,
  // go right, or stop.
  always_comb begin
    root       = subtree_root(up_state.size);
    step       = root + DATA_W'(1);
    state_next = up_state;
    if (up_state.active) begin
      if (up_state.rank > root) begin
        state_next.slot = (up_state.slot << 1) + DATA_W'(2);
        state_next.size = up_state.size - step;
        state_next.rank = up_state.rank - step;
      end else if (up_state.rank < root) begin
        state_next.slot = (up_state.slot << 1) + DATA_W'(1);
        state_next.size = root;
      end else begin
        state_next.active = 1'b0;
        state_next.found  = 1'b1;
      end
    end
  end

  // The cell takes a word when it is empty or its word moves on.
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state <= state_next;
    end
  end

  assign dn_valid = valid;
  assign dn_state = state;

  // A word that has hit its subtree root is never still active.
  a_found_not_active: assert property (@(posedge clk) disable iff (rst)
    valid |-> !(state.found && state.active))
    else $error("cell holds a word both found and active");

  // An active word keeps its rank inside its subtree.
  a_rank_in_subtree: assert property (@(posedge clk) disable iff (rst)
    (valid && state.active) |-> (state.rank < state.size))
    else $error("active rank outside its subtree");

  // A stalled word stays put.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (valid && !dn_ready) |=> (valid && $stable(state)))
    else $error("stalled word changed");

endmodule

[rtl/sorted_rank_to_cbst_index_top.sv]
// A chain of descent cells, one per tree level (INDEX_BITS), carries each accepted
// rank word to its slot word; each cell registers the word.
// Throughput: one word per cycle while m_tready holds; an empty cell takes a word even
// while a later cell is stalled, so a waiting result does not block new input until the chain fills.
// Reset (rst, synchronous): empties every cell and sets element_count to 1.
module sorted_rank_to_cbst_index_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream. s_tdata: [15:0] sorted_rank.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Output stream. m_tdata: [15:0] tree_slot. m_tuser: [0] rank_out_of_range.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [0:0]  m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [srcbi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srcbi_pkg::*;

  logic [DATA_W-1:0] element_count;
  logic              cfg_write;

  logic              chain_valid [INDEX_BITS+1];
  cell_state_t       chain_state [INDEX_BITS+1];
  logic              chain_ready [INDEX_BITS+1];

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_ELEMENT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEMENT_COUNT_RESET;
    end else if (cfg_write) begin
      element_count <= pwdata[DATA_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ELEMENT_COUNT) prdata = 32'(element_count);
  end

  // Head of the chain: a rank below the count starts descending.
  assign chain_valid[0] = s_tvalid;
  assign chain_state[0] = '{rank:   s_tdata,
                            size:   element_count,
                            slot:   '0,
                            active: (s_tdata < element_count),
                            found:  1'b0};
  assign s_tready = chain_ready[0];

  // One cell per tree level.
  for (genvar g = 0; g < INDEX_BITS; g++) begin : g_cell
    srcbi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[g]),
      .up_state (chain_state[g]),
      .up_ready (chain_ready[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_state (chain_state[g+1]),
      .dn_ready (chain_ready[g+1])
    );
  end

  // Tail of the chain: a word that never hit a root is flagged with slot 0.
  assign chain_ready[INDEX_BITS] = m_tready;
  assign m_tvalid   = chain_valid[INDEX_BITS];
  assign m_tdata    = chain_state[INDEX_BITS].found ? chain_state[INDEX_BITS].slot : '0;
  assign m_tuser[0] = !chain_state[INDEX_BITS].found;

  // Every descent ends within the chain for counts the slot field can hold.
  a_descent_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !chain_state[INDEX_BITS].active)
    else $error("word left the chain still descending");

  // An out-of-range rank enters the first cell already stopped and unfound.
  a_out_of_range_entry: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tdata >= element_count)) |=>
      (chain_valid[1] && !chain_state[1].active && !chain_state[1].found))
    else $error("out-of-range rank started a descent");

  // A slot word held back by the consumer stays on the output unchanged.
  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled slot word changed");

endmodule

[tb/sv/sorted_rank_to_cbst_index_top_tb.sv]
module sorted_rank_to_cbst_index_top_tb;

  import srcbi_pkg::*;

  localparam int LATENCY    = INDEX_BITS;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASE_LEN  = 150;

  // Tracks the configured element count and the slots still owed by the block.
  class slot_ledger;
    logic [DATA_W-1:0] element_count;
    // Each entry is {rank_out_of_range, tree_slot}.
    logic [DATA_W:0]   slots_due[$];
    int                mismatches;

    function new();
      element_count = ELEMENT_COUNT_RESET;
      mismatches    = 0;
    endfunction

    // Root rank of a complete search tree holding n elements.
    function int unsigned root_of(int unsigned n);
      int unsigned h;
      int unsigned full;
      int unsigned fill;
      int unsigned half;
      if (n <= 1) return 0;
      h    = $clog2(n + 1);
      full = (1 << (h - 1)) - 1;
      fill = n - full;
      half = 1 << (h - 2);
      if (half > fill) return full - (half - fill);
      return full;
    endfunction

    // Walks the tree from the top, one level per step, like the descent cells.
    function logic [DATA_W:0] predict_slot(logic [DATA_W-1:0] sorted_rank);
      int unsigned rank;
      int unsigned n;
      int unsigned slot;
      int unsigned root;
      bit          found;
      rank  = sorted_rank;
      n     = element_count;
      slot  = 0;
      found = 1'b0;
      if (rank < n) begin
        for (int lvl = 0; lvl < INDEX_BITS && !found; lvl++) begin
          root = root_of(n);
          if (rank > root) begin
            slot = 2 * slot + 2;
            n    = n - (root + 1);
            rank = rank - (root + 1);
          end else if (rank < root) begin
            slot = 2 * slot + 1;
            n    = root;
          end else begin
            found = 1'b1;
          end
        end
      end
      if (found) return {1'b0, DATA_W'(slot)};
      return {1'b1, DATA_W'(0)};
    endfunction

    function void note_rank(logic [DATA_W-1:0] sorted_rank);
      slots_due.push_back(predict_slot(sorted_rank));
    endfunction

    function void check_slot(logic [DATA_W-1:0] tree_slot, logic out_of_range);
      logic [DATA_W:0] want;
      if (slots_due.size() == 0) begin
        $display("%0t: unexpected slot word: slot %0d flag %0d",
                 $time, tree_slot, out_of_range);
        mismatches++;
        return;
      end
      want = slots_due.pop_front();
      if (tree_slot !== want[DATA_W-1:0]) begin
        $display("%0t: tree_slot expected %0d actual %0d",
                 $time, want[DATA_W-1:0], tree_slot);
        mismatches++;
      end
      if (out_of_range !== want[DATA_W]) begin
        $display("%0t: rank_out_of_range expected %0d actual %0d",
                 $time, want[DATA_W], out_of_range);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  slot_ledger ledger = new();
  bit         idle_on = 1'b1;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  sorted_rank_to_cbst_index_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offers one rank word after a random gap and returns at the edge that takes it.
  task send_rank(input logic [15:0] rank);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rank;
    do @(posedge clk); while (!s_tready);
    ledger.note_rank(rank);
  endtask

  // Writes element_count; the upper data bits carry noise the register drops.
  task write_count(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ELEMENT_COUNT;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.element_count = value;
  endtask

  // Waits for every owed slot, then lets the pipeline run empty.
  task drain;
    s_tvalid <= 1'b0;
    while (ledger.slots_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mostly in-range ranks, with some equal to the count and some drawn over the whole field.
  function logic [15:0] pick_rank(logic [15:0] count);
    if (count != 0 && $urandom_range(0, 99) < 85) return 16'($urandom_range(0, count - 1));
    if ($urandom_range(0, 9) == 0) return count;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Output side: check each slot word, then, while idling is on, may stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        ledger.check_slot(m_tdata, m_tuser[0]);
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
        if (stall_left > 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no word or register access moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] phase_counts[12];
    logic [15:0] count;
    phase_counts = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd8, 16'd100, 16'd32767,
                     16'd32768, 16'd65534, 16'd65535, 16'd0, 16'd1};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Count after reset is one: only rank zero fits.
    send_rank(16'd0);
    send_rank(16'd1);
    send_rank(16'hFFFF);
    drain();

    // Largest tree: deepest descent, edges of the rank field.
    write_count(16'hFFFF);
    send_rank(16'd0);
    send_rank(16'd1);
    send_rank(16'h7FFF);
    send_rank(16'h8000);
    send_rank(16'hAAAA);
    send_rank(16'h5555);
    send_rank(16'hFFFE);
    send_rank(16'hFFFF);
    drain();

    // Empty tree: every rank is out of range.
    write_count(16'd0);
    send_rank(16'd0);
    send_rank(16'hFFFF);
    drain();

    // Small trees with a partly filled bottom row.
    write_count(16'd6);
    for (int r = 0; r < 7; r++) send_rank(16'(r));
    drain();
    write_count(16'd2);
    send_rank(16'd0);
    send_rank(16'd1);
    send_rank(16'd2);
    drain();

    // Random phases, each under its own count; idling switches on and off in stretches.
    for (int p = 0; p < 12; p++) begin
      count = (p == 11) ? 16'($urandom_range(1, 65535)) : phase_counts[p];
      write_count(count);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_rank(pick_rank(count));
      end
      drain();
    end

    if (ledger.mismatches == 0 && ledger.slots_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
